// File: design/msk_pkg.sv
// Package for the multi-stack keyed removal block.
// Holds sizes, field widths, the id range and the status codes.
// No dependencies; every other design file uses it.
package msk_pkg;

  localparam int NUM_STACKS  = 8;
  localparam int STACK_DEPTH = 16;

  localparam int OP_W     = 1;
  localparam int SEL_W    = 3;
  localparam int ID_W     = 14;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;
  localparam int HSTK_W   = 3;
  localparam int HPOS_W   = 4;
  localparam int NCNT_W   = 5;

  localparam int ENTRY_W     = ID_W + OWNER_W;
  localparam int NUM_ENTRIES = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int STK_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [ID_W-1:0] ID_LOW  = ID_W'(1000);
  localparam logic [ID_W-1:0] ID_HIGH = ID_W'(9999);

  localparam logic [OP_W-1:0] OP_PUSH   = 1'b0;
  localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_ALL_FULL  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_ID    = 3'd4
  } status_e;

endpackage

// File: design/msk_if.sv
// Request and response channel interfaces of the multi-stack block.
// Valid/ready handshake with the payload fields; depends on msk_pkg.
interface msk_in_if;
  logic                         valid;
  logic                         ready;
  logic [msk_pkg::OP_W-1:0]     opcode;
  logic [msk_pkg::SEL_W-1:0]    stack_select;
  logic [msk_pkg::ID_W-1:0]     container_id;
  logic [msk_pkg::OWNER_W-1:0]  owner_code;

  modport source (output valid, opcode, stack_select, container_id, owner_code,
                  input ready);
  modport sink   (input valid, opcode, stack_select, container_id, owner_code,
                  output ready);
endinterface

interface msk_out_if;
  logic                          valid;
  logic                          ready;
  logic [msk_pkg::STATUS_W-1:0]  status;
  logic [msk_pkg::HSTK_W-1:0]    hit_stack;
  logic [msk_pkg::HPOS_W-1:0]    hit_position;
  logic [msk_pkg::NCNT_W-1:0]    new_count;
  logic [msk_pkg::OWNER_W-1:0]   removed_owner;

  modport source (output valid, status, hit_stack, hit_position, new_count,
                  removed_owner, input ready);
  modport sink   (input valid, status, hit_stack, hit_position, new_count,
                  removed_owner, output ready);
endinterface

// File: design/multi_stack_keyed_removal_top.sv
// Multi-stack keyed removal: top level with entry memory and sequencer.
// Depends on msk_pkg and the channel interfaces in msk_if.sv.
//
// The block holds NUM_STACKS bounded stacks in one single-port-write, registered-read
// entry memory, with the per-stack counts in flip-flops. A push, or a request with an
// id outside 1000..9999, goes from acceptance through S_FINISH into the output
// register with no memory scan. A remove scans the memory one entry per cycle, stack
// by stack from the bottom up, with a step between stacks for moving on, then closes
// the gap above the hit by moving each entry above it down one place, a read state
// and then a write state per moved entry (S_SHIFT_RD, then S_SHIFT_WR). One request
// is in work at a time; the result sits in an output register, so a new request is
// taken while the previous result waits to be collected. No clearing pass is needed
// after reset.
module multi_stack_keyed_removal_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  msk_in_if.sink    in_i,
  msk_out_if.source out_o
);
  import msk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_SHIFT_RD = 5'b00100,
    S_SHIFT_WR = 5'b01000,
    S_FINISH   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] counts_q [NUM_STACKS];
  logic [CNT_W-1:0] counts_d [NUM_STACKS];

  // Entry memory.
  logic [ENTRY_W-1:0] mem [NUM_ENTRIES];
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, rdata_q;

  // Scan and shift registers.
  logic [ID_W-1:0]    key_q, key_d;
  logic [STK_W-1:0]   s_q, s_d;
  logic [CNT_W-1:0]   p_q, p_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic               scan_done_q, scan_done_d;
  logic               rd_valid_q, rd_valid_d;
  logic [STK_W-1:0]   rd_s_q, rd_s_d;
  logic [CNT_W-1:0]   rd_p_q, rd_p_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [ADDR_W-1:0]  rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]   sh_k_q, sh_k_d;
  logic [ADDR_W-1:0]  sh_addr_q, sh_addr_d;

  // Pending result and output register.
  status_e             res_status_q, res_status_d;
  logic [HSTK_W-1:0]   res_stack_q, res_stack_d;
  logic [HPOS_W-1:0]   res_pos_q, res_pos_d;
  logic [NCNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic [OWNER_W-1:0]  res_owner_q, res_owner_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [HSTK_W-1:0]   out_stack_q;
  logic [HPOS_W-1:0]   out_pos_q;
  logic [NCNT_W-1:0]   out_cnt_q;
  logic [OWNER_W-1:0]  out_owner_q;
  logic                out_load;

  logic               in_acc, id_bad, sel_ok, all_full, last_stack, match, issue;
  logic [STK_W-1:0]   sel_idx, cnt_ridx;
  logic [CNT_W-1:0]   cnt_rd;
  logic [ADDR_W-1:0]  push_addr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign id_bad  = (in_i.container_id < ID_LOW) || (in_i.container_id > ID_HIGH);
  assign sel_ok  = (32'(in_i.stack_select) < 32'(NUM_STACKS));
  assign sel_idx = STK_W'(in_i.stack_select);

  // Push and scan share one indexed count read; all_full reads every count.
  assign cnt_ridx = (state_q == S_IDLE) ? sel_idx : s_q;
  assign cnt_rd   = (state_q == S_IDLE && !sel_ok) ? '0 : counts_q[cnt_ridx];

  always_comb begin
    all_full = 1'b1;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (counts_q[i] < CNT_W'(STACK_DEPTH)) begin
        all_full = 1'b0;
      end
    end
  end

  assign push_addr  = ADDR_W'(32'(sel_idx) * 32'(STACK_DEPTH) + 32'(cnt_rd));
  assign last_stack = (s_q == STK_W'(NUM_STACKS - 1));
  assign issue      = (state_q == S_SCAN) && !scan_done_q && (p_q < cnt_rd);
  assign match      = rd_valid_q && (rdata_q[ID_W-1:0] == key_q);
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    counts_d     = counts_q;
    key_d        = key_q;
    s_d          = s_q;
    p_d          = p_q;
    base_d       = base_q;
    scan_done_d  = scan_done_q;
    rd_valid_d   = 1'b0;
    rd_s_d       = rd_s_q;
    rd_p_d       = rd_p_q;
    rd_cnt_d     = rd_cnt_q;
    rd_addr_d    = rd_addr_q;
    sh_k_d       = sh_k_q;
    sh_addr_d    = sh_addr_q;
    res_status_d = res_status_q;
    res_stack_d  = res_stack_q;
    res_pos_d    = res_pos_q;
    res_cnt_d    = res_cnt_q;
    res_owner_d  = res_owner_q;
    mem_we       = 1'b0;
    mem_waddr    = push_addr;
    mem_wdata    = {in_i.owner_code, in_i.container_id};
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(base_q + ADDR_W'(p_q));

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_stack_d = '0;
          res_pos_d   = '0;
          res_cnt_d   = '0;
          res_owner_d = '0;
          state_d     = S_FINISH;
          if (id_bad) begin
            res_status_d = ST_BAD_ID;
          end else if (in_i.opcode == OP_PUSH) begin
            res_stack_d = HSTK_W'(in_i.stack_select);
            if (all_full) begin
              res_status_d = ST_ALL_FULL;
            end else if (!sel_ok) begin
              res_status_d = ST_FULL;
            end else if (cnt_rd >= CNT_W'(STACK_DEPTH)) begin
              res_status_d = ST_FULL;
              res_cnt_d    = NCNT_W'(cnt_rd);
            end else begin
              mem_we            = 1'b1;
              counts_d[sel_idx] = cnt_rd + CNT_W'(1);
              res_status_d      = ST_OK;
              res_pos_d         = HPOS_W'(cnt_rd);
              res_cnt_d         = NCNT_W'(cnt_rd + CNT_W'(1));
            end
          end else begin
            key_d       = in_i.container_id;
            s_d         = '0;
            p_d         = '0;
            base_d      = '0;
            scan_done_d = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads go out one per cycle within a stack, compared in the next cycle.
        if (issue) begin
          mem_re     = 1'b1;
          rd_valid_d = 1'b1;
          rd_s_d     = s_q;
          rd_p_d     = p_q;
          rd_cnt_d   = cnt_rd;
          rd_addr_d  = mem_raddr;
          p_d        = p_q + CNT_W'(1);
        end else if (!scan_done_q) begin
          if (last_stack) begin
            scan_done_d = 1'b1;
          end else begin
            s_d    = s_q + STK_W'(1);
            p_d    = '0;
            base_d = ADDR_W'(base_q + ADDR_W'(STACK_DEPTH));
          end
        end
        if (match) begin
          rd_valid_d   = 1'b0;
          sh_k_d       = rd_p_q;
          sh_addr_d    = rd_addr_q;
          res_status_d = ST_OK;
          res_stack_d  = HSTK_W'(rd_s_q);
          res_pos_d    = HPOS_W'(rd_p_q);
          res_cnt_d    = NCNT_W'(rd_cnt_q - CNT_W'(1));
          res_owner_d  = rdata_q[ENTRY_W-1:ID_W];
          state_d      = S_SHIFT_RD;
        end else if (scan_done_q && !rd_valid_q) begin
          res_status_d = ST_NOT_FOUND;
          res_stack_d  = '0;
          res_pos_d    = '0;
          res_cnt_d    = '0;
          res_owner_d  = '0;
          state_d      = S_FINISH;
        end
      end

      S_SHIFT_RD: begin
        if ((sh_k_q + CNT_W'(1)) < rd_cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(sh_addr_q + ADDR_W'(1));
          state_d   = S_SHIFT_WR;
        end else begin
          counts_d[rd_s_q] = rd_cnt_q - CNT_W'(1);
          state_d          = S_FINISH;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_addr_q;
        mem_wdata = rdata_q;
        sh_addr_d = ADDR_W'(sh_addr_q + ADDR_W'(1));
        sh_k_d    = sh_k_q + CNT_W'(1);
        state_d   = S_SHIFT_RD;
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_done_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      scan_done_q <= scan_done_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      counts_q    <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    s_q          <= s_d;
    p_q          <= p_d;
    base_q       <= base_d;
    rd_s_q       <= rd_s_d;
    rd_p_q       <= rd_p_d;
    rd_cnt_q     <= rd_cnt_d;
    rd_addr_q    <= rd_addr_d;
    sh_k_q       <= sh_k_d;
    sh_addr_q    <= sh_addr_d;
    res_status_q <= res_status_d;
    res_stack_q  <= res_stack_d;
    res_pos_q    <= res_pos_d;
    res_cnt_q    <= res_cnt_d;
    res_owner_q  <= res_owner_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_stack_q  <= res_stack_q;
      out_pos_q    <= res_pos_q;
      out_cnt_q    <= res_cnt_q;
      out_owner_q  <= res_owner_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.hit_stack     = out_stack_q;
  assign out_o.hit_position  = out_pos_q;
  assign out_o.new_count     = out_cnt_q;
  assign out_o.removed_owner = out_owner_q;

endmodule

// File: design/msk_checker.sv
// Port-level checks for the multi-stack keyed removal block, and their binding.
// Depends on msk_pkg and on the top level's channel ports.
module msk_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [msk_pkg::STATUS_W-1:0]         status_i,
  input logic [msk_pkg::OWNER_W-1:0]          removed_owner_i
);
  import msk_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests taken whose result has not yet been collected.
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result shown with no request outstanding");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request taken while the previous one is still in work");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK || status_i == ST_FULL ||
                     status_i == ST_ALL_FULL || status_i == ST_NOT_FOUND ||
                     status_i == ST_BAD_ID) &&
                    (status_i == ST_OK || removed_owner_i == '0))
    else $error("illegal status, or owner returned on a failed request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
                                    $stable(removed_owner_i))
    else $error("stalled result dropped or changed");

endmodule

bind multi_stack_keyed_removal_top msk_checker u_msk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .removed_owner_i (out_o.removed_owner)
);
